// ===== sv/ufd_pkg.sv =====
// ----------------------------------------------------------------------------
// ufd_pkg
// Shared types and constants of the UART frame deframer: store geometry,
// register indexes, drop reasons, parser steps and the result beat.
// ----------------------------------------------------------------------------
package ufd_pkg;

  localparam int BufferDepth = 64;
  localparam int MaxItems    = 64;
  localparam int StoreDepth  = (BufferDepth < MaxItems) ? BufferDepth : MaxItems;
  localparam int AddrW       = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam int CountW      = 7;
  localparam int TickW       = 17;

  localparam logic [TickW-1:0]  TickMax         = '1;
  localparam logic [CountW-1:0] StoreDepthCount = CountW'(StoreDepth);

  localparam logic [7:0]        StartMarkerReset = 8'd2;
  localparam logic [7:0]        StopMarkerReset  = 8'd3;
  localparam logic [15:0]       TimeoutReset     = 16'd0;
  localparam logic [CountW-1:0] BufferLenReset   = 7'd64;

  localparam logic ModeByte = 1'b0;
  localparam logic ModeTick = 1'b1;

  localparam logic KindPayload = 1'b0;
  localparam logic KindDrop    = 1'b1;

  typedef enum logic [1:0] {
    CfgStartMarker = 2'd0,
    CfgStopMarker  = 2'd1,
    CfgTimeoutMs   = 2'd2,
    CfgBufferLen   = 2'd3
  } cfg_index_e;

  typedef enum logic [1:0] {
    DropTimeout = 2'd0,
    DropTooLong = 2'd1,
    DropBadSum  = 2'd2,
    DropBadStop = 2'd3
  } drop_reason_e;

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StId   = 6'b000010,
    StLen  = 6'b000100,
    StPay  = 6'b001000,
    StSum  = 6'b010000,
    StStop = 6'b100000
  } parse_step_e;

  typedef struct packed {
    logic         kind;
    drop_reason_e drop_reason;
    logic [7:0]   frame_tag;
    logic [7:0]   payload_byte;
    logic         byte_valid;
    logic [5:0]   byte_index;
    logic [6:0]   frame_length;
    logic         last;
  } result_t;

endpackage

// ===== sv/ufd_out_reg.sv =====
// ----------------------------------------------------------------------------
// ufd_out_reg
// Output register of the deframer: holds one result beat while the
// receiver stalls and takes a new beat in the cycle the old one leaves.
// ----------------------------------------------------------------------------
module ufd_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ufd_pkg::result_t  item_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              stall_i,
  output ufd_pkg::result_t  item_o
);
  import ufd_pkg::*;

  logic    valid_q;
  result_t item_q;

  assign ready_o = !valid_q || !stall_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (!stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      item_q <= item_i;
    end
  end

endmodule

// ===== sv/uart_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// uart_frame_deframer
// Parses start, id, length, payload, checksum, stop frames from a byte and
// tick stream; emits accepted payload as a run of beats or one drop beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): mode_i = 0 carries a received
//   byte in data_byte_i, mode_i = 1 is a one millisecond tick. Each input
//   beat is parsed as it is taken; a beat that drops a frame or closes an
//   empty frame puts its result into the output register at the edge that takes it.
//   A stop byte that closes a frame of n payload bytes starts a read-out of
//   the payload store: one single-port read per cycle unless the output
//   stalls; each read goes to the read register, then the output register,
//   for one beat per unstalled cycle. Input stays stalled while it drains.
//   Output channel (out_valid_o / out_stall_i): one result beat per item;
//   a stalled beat holds, and a new input beat is taken in the cycle the
//   held beat leaves. Configuration (cfg_valid_i / cfg_ready_o) is always
//   ready; write it only while no frame output is pending.
//   Reset clears the parser, tick counter and registers to their defaults;
//   the payload store needs no clearing pass, it is read only where the
//   current frame wrote it.
// ----------------------------------------------------------------------------
module uart_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [1:0]  drop_reason_o,
  output logic [7:0]  frame_tag_o,
  output logic [7:0]  payload_byte_o,
  output logic        byte_valid_o,
  output logic [5:0]  byte_index_o,
  output logic [6:0]  frame_length_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import ufd_pkg::*;

  logic [7:0]        start_q;
  logic [7:0]        stop_q;
  logic [15:0]       timeout_q;
  logic [CountW-1:0] buflen_q;

  parse_step_e       step_q, step_d;
  logic [7:0]        tag_q, tag_d;
  logic [CountW-1:0] hlen_q, hlen_d;
  logic [CountW-1:0] rcnt_q, rcnt_d;
  logic [7:0]        sum_q, sum_d;
  logic [TickW-1:0]  elapsed_q, elapsed_d;

  logic              emit_q;
  logic [CountW-1:0] em_idx_q;
  logic [CountW-1:0] em_len_q;
  logic [7:0]        em_tag_q;

  logic              rd_vld_q;
  logic [5:0]        rd_idx_q;
  logic              rd_last_q;
  logic [7:0]        rd_data_q;

  logic [7:0]        store_mem [StoreDepth];

  logic              in_acc;
  logic              oreg_ready;
  logic              timed_out;
  parse_step_e       eff_step;
  logic [CountW-1:0] lim;
  logic [7:0]        sum_add;
  logic [CountW-1:0] rcnt_inc;
  logic              do_clear;
  logic              emit_start;
  logic              wr_en;
  logic              in_push;
  result_t           in_item;
  logic              rd_issue;
  logic              rd_move;
  logic [CountW-1:0] em_next;
  logic              em_last;
  logic              push;
  result_t           push_item;
  result_t           out_item;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = emit_q || rd_vld_q || !oreg_ready;
  assign in_acc      = in_valid_i && !in_stall_o;

  assign lim      = (buflen_q > StoreDepthCount) ? StoreDepthCount : buflen_q;
  assign sum_add  = sum_q + data_byte_i;
  assign rcnt_inc = rcnt_q + 1'b1;

  always_comb begin
    step_d     = step_q;
    tag_d      = tag_q;
    hlen_d     = hlen_q;
    rcnt_d     = rcnt_q;
    sum_d      = sum_q;
    elapsed_d  = elapsed_q;
    do_clear   = 1'b0;
    emit_start = 1'b0;
    wr_en      = 1'b0;
    in_push    = 1'b0;
    in_item    = '0;
    timed_out  = (step_q != StIdle) && (timeout_q != '0) &&
                 (elapsed_q > {1'b0, timeout_q});
    eff_step   = timed_out ? StIdle : step_q;

    if (in_acc) begin
      if (mode_i == ModeTick) begin
        if (elapsed_q != TickMax) begin
          elapsed_d = elapsed_q + 1'b1;
        end
      end else begin
        if (timed_out) begin
          in_push             = 1'b1;
          in_item.kind        = KindDrop;
          in_item.drop_reason = DropTimeout;
          in_item.last        = 1'b1;
          do_clear            = 1'b1;
        end
        unique case (eff_step)
          StIdle: begin
            if (data_byte_i == start_q) begin
              do_clear  = 1'b0;
              tag_d     = '0;
              hlen_d    = '0;
              rcnt_d    = '0;
              sum_d     = '0;
              elapsed_d = '0;
              step_d    = StId;
            end
          end
          StId: begin
            tag_d  = data_byte_i;
            sum_d  = sum_add;
            step_d = StLen;
          end
          StLen: begin
            if (data_byte_i > {1'b0, lim}) begin
              in_push             = 1'b1;
              in_item.kind        = KindDrop;
              in_item.drop_reason = DropTooLong;
              in_item.last        = 1'b1;
              do_clear            = 1'b1;
            end else begin
              hlen_d = data_byte_i[CountW-1:0];
              rcnt_d = '0;
              sum_d  = sum_add;
              step_d = (data_byte_i == 8'd0) ? StSum : StPay;
            end
          end
          StPay: begin
            if (rcnt_q >= lim) begin
              in_push             = 1'b1;
              in_item.kind        = KindDrop;
              in_item.drop_reason = DropTooLong;
              in_item.last        = 1'b1;
              do_clear            = 1'b1;
            end else begin
              wr_en  = 1'b1;
              sum_d  = sum_add;
              rcnt_d = rcnt_inc;
              step_d = (rcnt_inc >= hlen_q) ? StSum : StPay;
            end
          end
          StSum: begin
            if (~sum_q != data_byte_i) begin
              in_push             = 1'b1;
              in_item.kind        = KindDrop;
              in_item.drop_reason = DropBadSum;
              in_item.last        = 1'b1;
              do_clear            = 1'b1;
            end else begin
              step_d = StStop;
            end
          end
          StStop: begin
            do_clear = 1'b1;
            if (data_byte_i != stop_q) begin
              in_push             = 1'b1;
              in_item.kind        = KindDrop;
              in_item.drop_reason = DropBadStop;
              in_item.last        = 1'b1;
            end else if (rcnt_q == '0) begin
              in_push           = 1'b1;
              in_item.kind      = KindPayload;
              in_item.frame_tag = tag_q;
              in_item.last      = 1'b1;
            end else begin
              emit_start = 1'b1;
            end
          end
          default: begin
            do_clear = 1'b1;
          end
        endcase
        if (do_clear) begin
          step_d = StIdle;
          tag_d  = '0;
          hlen_d = '0;
          rcnt_d = '0;
          sum_d  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= StartMarkerReset;
      stop_q    <= StopMarkerReset;
      timeout_q <= TimeoutReset;
      buflen_q  <= BufferLenReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgStartMarker: start_q   <= cfg_data_i[7:0];
        CfgStopMarker:  stop_q    <= cfg_data_i[7:0];
        CfgTimeoutMs:   timeout_q <= cfg_data_i;
        CfgBufferLen:   buflen_q  <= cfg_data_i[CountW-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= StIdle;
      tag_q     <= '0;
      hlen_q    <= '0;
      rcnt_q    <= '0;
      sum_q     <= '0;
      elapsed_q <= '0;
    end else begin
      step_q    <= step_d;
      tag_q     <= tag_d;
      hlen_q    <= hlen_d;
      rcnt_q    <= rcnt_d;
      sum_q     <= sum_d;
      elapsed_q <= elapsed_d;
    end
  end

  assign rd_move  = rd_vld_q && oreg_ready;
  assign rd_issue = emit_q && (!rd_vld_q || oreg_ready);
  assign em_next  = em_idx_q + 1'b1;
  assign em_last  = (em_next == em_len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_q    <= 1'b0;
      em_idx_q  <= '0;
      em_len_q  <= '0;
      em_tag_q  <= '0;
      rd_vld_q  <= 1'b0;
      rd_idx_q  <= '0;
      rd_last_q <= 1'b0;
    end else begin
      if (emit_start) begin
        emit_q   <= 1'b1;
        em_idx_q <= '0;
        em_len_q <= rcnt_q;
        em_tag_q <= tag_q;
      end else if (rd_issue) begin
        em_idx_q <= em_next;
        if (em_last) begin
          emit_q <= 1'b0;
        end
      end
      if (rd_issue) begin
        rd_vld_q  <= 1'b1;
        rd_idx_q  <= em_idx_q[5:0];
        rd_last_q <= em_last;
      end else if (rd_move) begin
        rd_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[rcnt_q[AddrW-1:0]] <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_issue) begin
      rd_data_q <= store_mem[em_idx_q[AddrW-1:0]];
    end
  end

  always_comb begin
    push      = in_push || rd_move;
    push_item = in_item;
    if (rd_move) begin
      push_item              = '0;
      push_item.kind         = KindPayload;
      push_item.frame_tag    = em_tag_q;
      push_item.payload_byte = rd_data_q;
      push_item.byte_valid   = 1'b1;
      push_item.byte_index   = rd_idx_q;
      push_item.frame_length = em_len_q;
      push_item.last         = rd_last_q;
    end
  end

  ufd_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .ready_o (oreg_ready),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .item_o  (out_item)
  );

  assign kind_o         = out_item.kind;
  assign drop_reason_o  = out_item.drop_reason;
  assign frame_tag_o    = out_item.frame_tag;
  assign payload_byte_o = out_item.payload_byte;
  assign byte_valid_o   = out_item.byte_valid;
  assign byte_index_o   = out_item.byte_index;
  assign frame_length_o = out_item.frame_length;
  assign last_o         = out_item.last;

endmodule

// ===== sv/ufd_chk.sv =====
// ----------------------------------------------------------------------------
// ufd_chk
// Port-level checks of the UART frame deframer, bound to the top level.
// ----------------------------------------------------------------------------
module ufd_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        kind_o,
  input logic        byte_valid_o,
  input logic [5:0]  byte_index_o,
  input logic [6:0]  frame_length_o,
  input logic        last_o
);
  import ufd_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped under stall");

  a_drop_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KindDrop) |-> last_o && !byte_valid_o && (frame_length_o == '0))
    else $error("drop beat malformed");

  a_empty_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KindPayload) && !byte_valid_o |-> last_o && (frame_length_o == '0))
    else $error("empty frame beat malformed");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KindPayload) && byte_valid_o |->
      ({1'b0, byte_index_o} < frame_length_o))
    else $error("payload index beyond frame length");

  a_stall_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while output blocked");

endmodule

bind uart_frame_deframer ufd_chk u_ufd_chk (.*);

// ===== tb/tb_uart_frame_deframer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_uart_frame_deframer
// Self-checking bench for the frame deframer. Frames, broken frames, noise
// and ticks go in through a bursty sender while the result side stalls on
// its own pattern; a scoreboard class predicts every result beat and
// compares each one, field by field, as it leaves the block.
// ----------------------------------------------------------------------------
module tb_uart_frame_deframer;
  import ufd_pkg::*;

  typedef enum {
    FrameClean,
    FrameBadSum,
    FrameBadStop,
    FrameTooLong,
    FrameTimeout,
    FrameCut,
    FrameAtLimit
  } frame_flaw_e;

  class frame_checker;
    logic [7:0]        start_marker;
    logic [7:0]        stop_marker;
    logic [15:0]       timeout_ms;
    logic [CountW-1:0] buffer_len;

    parse_step_e       step;
    logic [7:0]        held_tag;
    logic [CountW-1:0] held_len;
    logic [CountW-1:0] rx_count;
    logic [7:0]        sum;
    logic [TickW-1:0]  ticks;
    logic [7:0]        store [StoreDepth];

    result_t pending_results [$];
    int errors;
    int results_checked;
    int frames_ok;
    int drops [4];

    function new();
      start_marker = StartMarkerReset;
      stop_marker  = StopMarkerReset;
      timeout_ms   = TimeoutReset;
      buffer_len   = BufferLenReset;
      ticks        = '0;
      clear_frame();
      errors = 0;
      results_checked = 0;
      frames_ok = 0;
      foreach (drops[i]) drops[i] = 0;
    endfunction

    function void clear_frame();
      step     = StIdle;
      held_tag = '0;
      held_len = '0;
      rx_count = '0;
      sum      = '0;
    endfunction

    function void write_reg(cfg_index_e idx, logic [15:0] val);
      case (idx)
        CfgStartMarker: start_marker = val[7:0];
        CfgStopMarker:  stop_marker  = val[7:0];
        CfgTimeoutMs:   timeout_ms   = val;
        CfgBufferLen:   buffer_len   = val[CountW-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned limit();
      return (buffer_len > StoreDepth) ? StoreDepth : buffer_len;
    endfunction

    function void push_drop(drop_reason_e reason);
      result_t r;
      r = '0;
      r.kind = KindDrop;
      r.drop_reason = reason;
      r.last = 1'b1;
      pending_results.push_back(r);
      clear_frame();
    endfunction

    function void predict_beat(logic m, logic [7:0] b);
      result_t r;
      int unsigned i;
      if (m == ModeTick) begin
        if (ticks != TickMax) ticks = ticks + 1'b1;
        return;
      end
      if (step != StIdle && timeout_ms != 0 && ticks > TickW'(timeout_ms))
        push_drop(DropTimeout);
      case (step)
        StIdle: begin
          if (b == start_marker) begin
            sum   = '0;
            ticks = '0;
            step  = StId;
          end
        end
        StId: begin
          held_tag = b;
          sum = sum + b;
          step = StLen;
        end
        StLen: begin
          if (b > limit()) begin
            push_drop(DropTooLong);
          end else begin
            held_len = b[CountW-1:0];
            rx_count = '0;
            sum = sum + b;
            if (b == 8'd0) step = StSum;
            else step = StPay;
          end
        end
        StPay: begin
          if (rx_count >= limit()) begin
            push_drop(DropTooLong);
          end else begin
            store[rx_count[AddrW-1:0]] = b;
            sum = sum + b;
            rx_count = rx_count + 1'b1;
            if (rx_count >= held_len) step = StSum;
          end
        end
        StSum: begin
          if (8'(~sum) != b) push_drop(DropBadSum);
          else step = StStop;
        end
        StStop: begin
          if (b != stop_marker) begin
            push_drop(DropBadStop);
          end else begin
            r = '0;
            r.kind = KindPayload;
            r.frame_tag = held_tag;
            if (rx_count == 0) begin
              r.last = 1'b1;
              pending_results.push_back(r);
            end else begin
              for (i = 0; i < rx_count; i++) begin
                r.payload_byte = store[i];
                r.byte_valid   = 1'b1;
                r.byte_index   = 6'(i);
                r.frame_length = rx_count;
                r.last         = (i + 1 == rx_count);
                pending_results.push_back(r);
              end
            end
            clear_frame();
          end
        end
        default: clear_frame();
      endcase
    endfunction

    function void match_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      end
    endfunction

    function void check_result(result_t seen);
      result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual 0x%0h", $time, seen);
        return;
      end
      want = pending_results.pop_front();
      match_field("kind", want.kind, seen.kind);
      match_field("drop_reason", want.drop_reason, seen.drop_reason);
      match_field("frame_tag", want.frame_tag, seen.frame_tag);
      match_field("payload_byte", want.payload_byte, seen.payload_byte);
      match_field("byte_valid", want.byte_valid, seen.byte_valid);
      match_field("byte_index", want.byte_index, seen.byte_index);
      match_field("frame_length", want.frame_length, seen.frame_length);
      match_field("last", want.last, seen.last);
      results_checked++;
      if (want.kind == KindDrop) drops[want.drop_reason]++;
      else if (want.last) frames_ok++;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  localparam int QuietLimit = 3000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        mode = ModeByte;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        kind;
  logic [1:0]  drop_reason;
  logic [7:0]  frame_tag;
  logic [7:0]  payload_byte;
  logic        byte_valid;
  logic [5:0]  byte_index;
  logic [6:0]  frame_length;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_index_e  cfg_index = CfgStartMarker;
  logic [15:0] cfg_data = 16'h0000;

  frame_checker sb;

  int unsigned burst_left = 0;
  int unsigned beats_sent = 0;
  int unsigned noise_beats = 0;
  int unsigned tick_pct = 0;
  int unsigned stall_style = 0;
  int unsigned style_left = 0;

  uart_frame_deframer DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .mode_i         (mode),
    .data_byte_i    (data_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .kind_o         (kind),
    .drop_reason_o  (drop_reason),
    .frame_tag_o    (frame_tag),
    .payload_byte_o (payload_byte),
    .byte_valid_o   (byte_valid),
    .byte_index_o   (byte_index),
    .frame_length_o (frame_length),
    .last_o         (last),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(negedge clk) begin
    if (style_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      style_left  <= $urandom_range(30, 200);
    end else begin
      style_left <= style_left - 1;
    end
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 99) < 35);
      2: out_stall <= (style_left[1:0] != 2'd0);
      default: if ($urandom_range(0, 11) == 0) out_stall <= ~out_stall;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({kind, drop_reason, frame_tag, payload_byte, byte_valid,
                       byte_index, frame_length, last});
  end

  task automatic drive_beat(input logic m, input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(1, 10);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid  <= 1'b1;
    mode      <= m;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.predict_beat(m, b);
    beats_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_e idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic sprinkle_ticks();
    if (tick_pct != 0 && $urandom_range(0, 99) < tick_pct)
      repeat ($urandom_range(1, 2)) drive_beat(ModeTick, 8'($urandom));
  endtask

  function automatic logic [7:0] pick_payload();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_len(frame_flaw_e flaw);
    int unsigned lim;
    int unsigned cap;
    lim = sb.limit();
    if (flaw == FrameTooLong) return $urandom_range(lim + 1, 255);
    cap = (lim < 6) ? lim : 6;
    if ($urandom_range(0, 23) == 0) return lim;
    return $urandom_range(0, cap);
  endfunction

  function automatic frame_flaw_e choose_flaw();
    int unsigned r;
    bit timed;
    r = $urandom_range(0, 99);
    timed = (sb.timeout_ms != 0) && (sb.timeout_ms <= 20);
    if (r < 55) return FrameClean;
    if (r < 65) return FrameBadSum;
    if (r < 75) return FrameBadStop;
    if (r < 85) return FrameTooLong;
    if (r < 96) begin
      if (!timed) return FrameClean;
      if (r < 93) return FrameTimeout;
      return FrameAtLimit;
    end
    return FrameCut;
  endfunction

  task automatic send_frame(input logic [7:0] tag, input int unsigned len,
                            input frame_flaw_e flaw);
    logic [7:0] sum;
    logic [7:0] pb;
    int unsigned stop_at;
    int unsigned i;
    stop_at = (flaw == FrameTimeout || flaw == FrameCut) ? $urandom_range(0, len) : len + 1;
    sum = tag + 8'(len);
    sprinkle_ticks();
    drive_beat(ModeByte, sb.start_marker);
    sprinkle_ticks();
    drive_beat(ModeByte, tag);
    if (flaw == FrameAtLimit) repeat (sb.timeout_ms) drive_beat(ModeTick, 8'($urandom));
    sprinkle_ticks();
    drive_beat(ModeByte, 8'(len));
    if (flaw == FrameTooLong) return;
    for (i = 0; i <= len; i++) begin
      if (i == stop_at) begin
        if (flaw == FrameTimeout)
          repeat (sb.timeout_ms + $urandom_range(1, 3)) drive_beat(ModeTick, 8'($urandom));
        return;
      end
      if (i < len) begin
        pb = pick_payload();
        sum = sum + pb;
        sprinkle_ticks();
        drive_beat(ModeByte, pb);
      end
    end
    sprinkle_ticks();
    if (flaw == FrameBadSum) drive_beat(ModeByte, ~sum ^ 8'($urandom_range(1, 255)));
    else drive_beat(ModeByte, ~sum);
    sprinkle_ticks();
    if (flaw == FrameBadStop)
      drive_beat(ModeByte, sb.stop_marker ^ 8'($urandom_range(1, 255)));
    else
      drive_beat(ModeByte, sb.stop_marker);
  endtask

  task automatic run_random(input int unsigned target);
    int unsigned goal;
    frame_flaw_e flaw;
    goal = beats_sent - noise_beats + target;
    while (beats_sent - noise_beats < goal) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          drive_beat(1'($urandom), 8'($urandom));
          noise_beats++;
        end
      end else begin
        flaw = choose_flaw();
        send_frame(8'($urandom), pick_len(flaw), flaw);
      end
    end
  endtask

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no handshake for %0d cycles", $time, QuietLimit);
    $display("simulation failed");
    $finish;
  end

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_frame(8'hFF, 0, FrameClean);
    send_frame(8'h00, 2, FrameClean);
    send_frame(8'h3C, 65, FrameTooLong);
    send_frame(8'h81, 1, FrameBadSum);
    send_frame(8'h7E, 0, FrameBadStop);
    settle();

    write_reg(CfgStartMarker, 16'h0000);
    write_reg(CfgStopMarker, 16'h00FF);
    write_reg(CfgTimeoutMs, 16'd2);
    write_reg(CfgBufferLen, 16'd64);
    send_frame(8'h11, 0, FrameAtLimit);
    // leave a frame open past the timeout; the next start byte drops and reopens
    drive_beat(ModeByte, sb.start_marker);
    drive_beat(ModeByte, 8'h5A);
    repeat (3) drive_beat(ModeTick, 8'hFF);
    send_frame(8'hA5, 1, FrameClean);
    tick_pct = 8;
    run_random(15);
    settle();

    write_reg(CfgStartMarker, 16'h00FF);
    write_reg(CfgStopMarker, 16'h0000);
    write_reg(CfgTimeoutMs, 16'd0);
    write_reg(CfgBufferLen, 16'd0);
    tick_pct = 15;
    run_random(10);
    settle();

    write_reg(CfgStartMarker, 16'($urandom_range(0, 255)));
    write_reg(CfgStopMarker, 16'($urandom_range(0, 255)));
    write_reg(CfgTimeoutMs, 16'hFFFF);
    write_reg(CfgBufferLen, 16'($urandom_range(1, 16)));
    run_random(20);
    settle();

    write_reg(CfgStartMarker, 16'h0002);
    write_reg(CfgStopMarker, 16'h0003);
    write_reg(CfgTimeoutMs, 16'($urandom_range(5, 20)));
    write_reg(CfgBufferLen, 16'd64);
    tick_pct = 0;
    send_frame(8'($urandom), 64, FrameClean);
    // hold the sender until the full payload run has drained
    settle();
    tick_pct = 10;
    run_random(10);
    settle();

    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
    end
    $display("covered %0d input beats and %0d result beats over five register settings",
             beats_sent, sb.results_checked);
    $display("frames accepted %0d; drops timeout %0d, too long %0d, bad sum %0d, bad stop %0d",
             sb.frames_ok, sb.drops[DropTimeout], sb.drops[DropTooLong],
             sb.drops[DropBadSum], sb.drops[DropBadStop]);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
